[hw/rtl/aarh_pkg.sv]
package aarh_pkg;

    localparam int COORD_W  = 32;
    localparam int FRAC_W   = 16;
    localparam int TEX_W    = FRAC_W + 1;
    localparam int MAT_W    = 8;
    localparam int ORIENT_W = 2;
    localparam int AXIS_W   = 2;
    localparam int IDX_W    = 3;

    // divider: numerator magnitude below 2^DIV_NUM_W, divisor magnitude fits DIV_DEN_W
    localparam int DIV_NUM_W = COORD_W + FRAC_W;
    localparam int DIV_DEN_W = COORD_W;

    localparam int PROD_W = 2 * COORD_W;
    localparam int PT_W   = PROD_W - FRAC_W + 1;
    localparam int TF_W   = DIV_NUM_W + 1;

    localparam logic [IDX_W-1:0] REG_ORIENT      = 3'd0;
    localparam logic [IDX_W-1:0] REG_PLANE_OFST  = 3'd1;
    localparam logic [IDX_W-1:0] REG_FIRST_LOW   = 3'd2;
    localparam logic [IDX_W-1:0] REG_FIRST_HIGH  = 3'd3;
    localparam logic [IDX_W-1:0] REG_SECOND_LOW  = 3'd4;
    localparam logic [IDX_W-1:0] REG_SECOND_HIGH = 3'd5;
    localparam logic [IDX_W-1:0] REG_MATERIAL    = 3'd6;

    localparam logic [ORIENT_W-1:0] ORIENT_XY = 2'd0;
    localparam logic [ORIENT_W-1:0] ORIENT_XZ = 2'd1;
    localparam logic [ORIENT_W-1:0] ORIENT_YZ = 2'd2;

    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        logic [COORD_W-1:0] org_x;
        logic [COORD_W-1:0] org_y;
        logic [COORD_W-1:0] org_z;
        logic [COORD_W-1:0] dir_x;
        logic [COORD_W-1:0] dir_y;
        logic [COORD_W-1:0] dir_z;
        logic [COORD_W-1:0] t_min;
        logic [COORD_W-1:0] t_max;
        logic               neg;
        logic               bad;
    } t_ray_tag;

    localparam int TAG_W = $bits(t_ray_tag);
    localparam int PAD_W = TAG_W - (1 + 4 * COORD_W + 2 + AXIS_W);

    typedef struct packed {
        logic               hit;
        logic [COORD_W-1:0] t;
        logic [COORD_W-1:0] pt_x;
        logic [COORD_W-1:0] pt_y;
        logic [COORD_W-1:0] pt_z;
        logic               zu;
        logic               zv;
        logic [AXIS_W-1:0]  axis;
        logic [PAD_W-1:0]   pad;
    } t_hit_tag;

endpackage

[hw/rtl/axis_aligned_rect_ray_hit.sv]
// Channel  | Direction | Handshake                 | Payload
// ray in   | input     | i_in_valid / o_in_stall   | origin, direction, t window
// hit out  | output    | o_out_valid / i_out_stall | hit, t, point, u, v, axis, material
// config   | input     | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// One beat per cycle in steady state while the output is not stalled.
// The beat passes two 48-step restoring dividers in series (t, then u and v side by side).
// Reset is synchronous, active low, clears valid bits and resets the config registers.
// A stalled output beat freezes the whole pipeline; bubbles are not squeezed out.
module axis_aligned_rect_ray_hit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [aarh_pkg::IDX_W-1:0]          i_cfg_idx,
    input  logic [aarh_pkg::COORD_W-1:0]        i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [aarh_pkg::COORD_W-1:0] i_origin_x,
    input  logic signed [aarh_pkg::COORD_W-1:0] i_origin_y,
    input  logic signed [aarh_pkg::COORD_W-1:0] i_origin_z,
    input  logic signed [aarh_pkg::COORD_W-1:0] i_dir_x,
    input  logic signed [aarh_pkg::COORD_W-1:0] i_dir_y,
    input  logic signed [aarh_pkg::COORD_W-1:0] i_dir_z,
    input  logic signed [aarh_pkg::COORD_W-1:0] i_t_min,
    input  logic signed [aarh_pkg::COORD_W-1:0] i_t_max,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_hit,
    output logic signed [aarh_pkg::COORD_W-1:0] o_hit_t,
    output logic signed [aarh_pkg::COORD_W-1:0] o_point_x,
    output logic signed [aarh_pkg::COORD_W-1:0] o_point_y,
    output logic signed [aarh_pkg::COORD_W-1:0] o_point_z,
    output logic [aarh_pkg::TEX_W-1:0]          o_tex_u,
    output logic [aarh_pkg::TEX_W-1:0]          o_tex_v,
    output logic [aarh_pkg::AXIS_W-1:0]         o_normal_axis,
    output logic [aarh_pkg::MAT_W-1:0]          o_hit_material
);
    import aarh_pkg::*;

    logic [ORIENT_W-1:0]      r_orient;
    logic signed [COORD_W-1:0] r_plane;
    logic signed [COORD_W-1:0] r_lo1;
    logic signed [COORD_W-1:0] r_hi1;
    logic signed [COORD_W-1:0] r_lo2;
    logic signed [COORD_W-1:0] r_hi2;
    logic [MAT_W-1:0]         r_mat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orient <= ORIENT_XY;
            r_plane  <= '0;
            r_lo1    <= '0;
            r_hi1    <= COORD_W'(1) << FRAC_W;
            r_lo2    <= '0;
            r_hi2    <= COORD_W'(1) << FRAC_W;
            r_mat    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ORIENT:      r_orient <= i_cfg_data[ORIENT_W-1:0];
                REG_PLANE_OFST:  r_plane  <= i_cfg_data;
                REG_FIRST_LOW:   r_lo1    <= i_cfg_data;
                REG_FIRST_HIGH:  r_hi1    <= i_cfg_data;
                REG_SECOND_LOW:  r_lo2    <= i_cfg_data;
                REG_SECOND_HIGH: r_hi2    <= i_cfg_data;
                REG_MATERIAL:    r_mat    <= i_cfg_data[MAT_W-1:0];
                default: ;
            endcase
        end
    end

    logic adv;
    assign adv        = !(o_out_valid && i_out_stall);
    assign o_in_stall = !adv;

    // stage 0: capture the ray
    logic                      r_s0_valid;
    logic signed [COORD_W-1:0] r_s0_ox, r_s0_oy, r_s0_oz;
    logic signed [COORD_W-1:0] r_s0_dx, r_s0_dy, r_s0_dz;
    logic signed [COORD_W-1:0] r_s0_tmin, r_s0_tmax;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (adv) begin
            r_s0_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s0_ox   <= i_origin_x;
            r_s0_oy   <= i_origin_y;
            r_s0_oz   <= i_origin_z;
            r_s0_dx   <= i_dir_x;
            r_s0_dy   <= i_dir_y;
            r_s0_dz   <= i_dir_z;
            r_s0_tmin <= i_t_min;
            r_s0_tmax <= i_t_max;
        end
    end

    logic signed [COORD_W-1:0] org_n, dir_n;
    logic                      no_plane;
    logic [AXIS_W-1:0]         axis_n;

    always_comb begin
        org_n    = r_s0_oz;
        dir_n    = r_s0_dz;
        axis_n   = AXIS_Z;
        no_plane = 1'b0;
        unique case (r_orient)
            ORIENT_XY: begin
                org_n  = r_s0_oz;
                dir_n  = r_s0_dz;
                axis_n = AXIS_Z;
            end
            ORIENT_XZ: begin
                org_n  = r_s0_oy;
                dir_n  = r_s0_dy;
                axis_n = AXIS_Y;
            end
            ORIENT_YZ: begin
                org_n  = r_s0_ox;
                dir_n  = r_s0_dx;
                axis_n = AXIS_X;
            end
            default: no_plane = 1'b1;
        endcase
    end

    logic signed [COORD_W:0]  diff_n;
    logic [COORD_W-1:0]       diff_mag;
    logic [DIV_DEN_W-1:0]     dir_mag;
    logic [DIV_NUM_W-1:0]     t_num;
    t_ray_tag                 ray_tag;

    assign diff_n   = (COORD_W+1)'(r_plane) - (COORD_W+1)'(org_n);
    assign diff_mag = diff_n[COORD_W] ? COORD_W'(-diff_n) : COORD_W'(diff_n);
    assign dir_mag  = dir_n[COORD_W-1] ? DIV_DEN_W'(-dir_n) : DIV_DEN_W'(dir_n);
    assign t_num    = {diff_mag, {FRAC_W{1'b0}}};

    always_comb begin
        ray_tag.org_x = r_s0_ox;
        ray_tag.org_y = r_s0_oy;
        ray_tag.org_z = r_s0_oz;
        ray_tag.dir_x = r_s0_dx;
        ray_tag.dir_y = r_s0_dy;
        ray_tag.dir_z = r_s0_dz;
        ray_tag.t_min = r_s0_tmin;
        ray_tag.t_max = r_s0_tmax;
        ray_tag.neg   = diff_n[COORD_W] ^ dir_n[COORD_W-1];
        ray_tag.bad   = no_plane || (dir_n == '0);
    end

    logic                 d1_valid;
    logic [DIV_NUM_W-1:0] d1_quo;
    logic [TAG_W-1:0]     d1_tag_raw;
    t_ray_tag             d1_tag;

    aarh_div u_div_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_s0_valid),
        .i_num   (t_num),
        .i_den   (dir_mag),
        .i_tag   (ray_tag),
        .o_valid (d1_valid),
        .o_quo   (d1_quo),
        .o_tag   (d1_tag_raw)
    );

    assign d1_tag = t_ray_tag'(d1_tag_raw);

    // window test on the full-precision quotient
    logic signed [TF_W-1:0] t_full;
    logic                   in_window;
    assign t_full    = d1_tag.neg ? -$signed({1'b0, d1_quo}) : $signed({1'b0, d1_quo});
    assign in_window = !d1_tag.bad
                    && t_full >= TF_W'($signed(d1_tag.t_min))
                    && t_full <= TF_W'($signed(d1_tag.t_max));

    logic                      r_w_valid, r_w_ok;
    logic signed [COORD_W-1:0] r_w_t;
    t_ray_tag                  r_w_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_valid <= 1'b0;
        end else if (adv) begin
            r_w_valid <= d1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_w_ok  <= in_window;
            r_w_t   <= COORD_W'(t_full);
            r_w_tag <= d1_tag;
        end
    end

    // t * dir for each axis
    logic                      r_m_valid, r_m_ok;
    logic signed [COORD_W-1:0] r_m_t;
    logic signed [COORD_W-1:0] r_m_ox, r_m_oy, r_m_oz;
    logic signed [PROD_W-1:0]  r_m_px, r_m_py, r_m_pz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (adv) begin
            r_m_valid <= r_w_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m_ok <= r_w_ok;
            r_m_t  <= r_w_t;
            r_m_ox <= r_w_tag.org_x;
            r_m_oy <= r_w_tag.org_y;
            r_m_oz <= r_w_tag.org_z;
            r_m_px <= r_w_t * $signed(r_w_tag.dir_x);
            r_m_py <= r_w_t * $signed(r_w_tag.dir_y);
            r_m_pz <= r_w_t * $signed(r_w_tag.dir_z);
        end
    end

    // hit point, full precision
    logic                      r_p_valid, r_p_ok;
    logic signed [COORD_W-1:0] r_p_t;
    logic signed [PT_W-1:0]    r_p_x, r_p_y, r_p_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (adv) begin
            r_p_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p_ok <= r_m_ok;
            r_p_t  <= r_m_t;
            r_p_x  <= PT_W'(r_m_ox) + PT_W'(r_m_px >>> FRAC_W);
            r_p_y  <= PT_W'(r_m_oy) + PT_W'(r_m_py >>> FRAC_W);
            r_p_z  <= PT_W'(r_m_oz) + PT_W'(r_m_pz >>> FRAC_W);
        end
    end

    logic signed [PT_W-1:0] c1, c2;
    logic [AXIS_W-1:0]      axis_p;

    always_comb begin
        c1     = r_p_x;
        c2     = r_p_y;
        axis_p = AXIS_Z;
        unique case (r_orient)
            ORIENT_XY: begin
                c1     = r_p_x;
                c2     = r_p_y;
                axis_p = AXIS_Z;
            end
            ORIENT_XZ: begin
                c1     = r_p_x;
                c2     = r_p_z;
                axis_p = AXIS_Y;
            end
            ORIENT_YZ: begin
                c1     = r_p_y;
                c2     = r_p_z;
                axis_p = AXIS_X;
            end
            default: ;
        endcase
    end

    localparam logic signed [PT_W-1:0] SAT_HI = PT_W'({1'b0, {(COORD_W-1){1'b1}}});
    localparam logic signed [PT_W-1:0] SAT_LO = -SAT_HI - PT_W'(1);

    function automatic logic [COORD_W-1:0] sat(input logic signed [PT_W-1:0] x);
        logic [COORD_W-1:0] res;
        if (x > SAT_HI) begin
            res = SAT_HI[COORD_W-1:0];
        end else if (x < SAT_LO) begin
            res = SAT_LO[COORD_W-1:0];
        end else begin
            res = x[COORD_W-1:0];
        end
        return res;
    endfunction

    logic                  in_bounds;
    logic signed [PT_W-1:0] du, dv;
    logic [COORD_W:0]      wu, wv;
    t_hit_tag              hit_tag;

    assign in_bounds = c1 >= PT_W'(r_lo1) && c1 <= PT_W'(r_hi1)
                    && c2 >= PT_W'(r_lo2) && c2 <= PT_W'(r_hi2);
    assign du = c1 - PT_W'(r_lo1);
    assign dv = c2 - PT_W'(r_lo2);
    assign wu = (COORD_W+1)'(r_hi1) - (COORD_W+1)'(r_lo1);
    assign wv = (COORD_W+1)'(r_hi2) - (COORD_W+1)'(r_lo2);

    always_comb begin
        hit_tag.hit  = r_p_ok && in_bounds;
        hit_tag.t    = r_p_t;
        hit_tag.pt_x = sat(r_p_x);
        hit_tag.pt_y = sat(r_p_y);
        hit_tag.pt_z = sat(r_p_z);
        hit_tag.zu   = r_hi1 == r_lo1;
        hit_tag.zv   = r_hi2 == r_lo2;
        hit_tag.axis = axis_p;
        hit_tag.pad  = '0;
    end

    logic                 d2_valid;
    logic [DIV_NUM_W-1:0] d2_quo_u, d2_quo_v;
    logic [TAG_W-1:0]     d2_tag_raw;
    t_hit_tag             d2_tag;

    aarh_div u_div_u (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_p_valid),
        .i_num   ({du[COORD_W-1:0], {FRAC_W{1'b0}}}),
        .i_den   (wu[DIV_DEN_W-1:0]),
        .i_tag   (hit_tag),
        .o_valid (d2_valid),
        .o_quo   (d2_quo_u),
        .o_tag   (d2_tag_raw)
    );

    aarh_div u_div_v (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_p_valid),
        .i_num   ({dv[COORD_W-1:0], {FRAC_W{1'b0}}}),
        .i_den   (wv[DIV_DEN_W-1:0]),
        .i_tag   ('0),
        .o_valid (),
        .o_quo   (d2_quo_v),
        .o_tag   ()
    );

    assign d2_tag = t_hit_tag'(d2_tag_raw);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (adv) begin
            o_out_valid <= d2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (d2_tag.hit) begin
                o_hit          <= 1'b1;
                o_hit_t        <= d2_tag.t;
                o_point_x      <= d2_tag.pt_x;
                o_point_y      <= d2_tag.pt_y;
                o_point_z      <= d2_tag.pt_z;
                o_tex_u        <= d2_tag.zu ? '0 : d2_quo_u[TEX_W-1:0];
                o_tex_v        <= d2_tag.zv ? '0 : d2_quo_v[TEX_W-1:0];
                o_normal_axis  <= d2_tag.axis;
                o_hit_material <= r_mat;
            end else begin
                o_hit          <= 1'b0;
                o_hit_t        <= '0;
                o_point_x      <= '0;
                o_point_y      <= '0;
                o_point_z      <= '0;
                o_tex_u        <= '0;
                o_tex_v        <= '0;
                o_normal_axis  <= '0;
                o_hit_material <= '0;
            end
        end
    end

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_hit |-> o_hit_t == '0 && o_tex_u == '0 && o_tex_v == '0
                                  && o_hit_material == '0)
        else $error("miss beat carries nonzero fields");

    a_tex_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_hit |-> o_tex_u <= TEX_W'(1) << FRAC_W
                                 && o_tex_v <= TEX_W'(1) << FRAC_W)
        else $error("texture coordinate above one");

    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_hit |-> o_normal_axis == AXIS_X || o_normal_axis == AXIS_Y
                                 || o_normal_axis == AXIS_Z)
        else $error("hit with no normal axis");

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output back-pressure");

endmodule

[hw/rtl/aarh_div.sv]
module aarh_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [aarh_pkg::DIV_NUM_W-1:0] i_num,
    input  logic [aarh_pkg::DIV_DEN_W-1:0] i_den,
    input  logic [aarh_pkg::TAG_W-1:0]     i_tag,
    output logic                          o_valid,
    output logic [aarh_pkg::DIV_NUM_W-1:0] o_quo,
    output logic [aarh_pkg::TAG_W-1:0]     o_tag
);
    import aarh_pkg::*;

    localparam int STAGES = DIV_NUM_W;

    logic                 r_vld [STAGES];
    logic [DIV_DEN_W-1:0] r_rem [STAGES];
    logic [DIV_NUM_W-1:0] r_num [STAGES];
    logic [DIV_NUM_W-1:0] r_quo [STAGES];
    logic [DIV_DEN_W-1:0] r_den [STAGES];
    logic [TAG_W-1:0]     r_tag [STAGES];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic                 vld_in;
        logic [DIV_DEN_W-1:0] rem_in;
        logic [DIV_NUM_W-1:0] num_in;
        logic [DIV_NUM_W-1:0] quo_in;
        logic [DIV_DEN_W-1:0] den_in;
        logic [TAG_W-1:0]     tag_in;
        logic [DIV_DEN_W:0]   trial;
        logic                 ge;

        if (k == 0) begin : g_first
            assign vld_in = i_valid;
            assign rem_in = '0;
            assign num_in = i_num;
            assign quo_in = '0;
            assign den_in = i_den;
            assign tag_in = i_tag;
        end else begin : g_next
            assign vld_in = r_vld[k-1];
            assign rem_in = r_rem[k-1];
            assign num_in = r_num[k-1];
            assign quo_in = r_quo[k-1];
            assign den_in = r_den[k-1];
            assign tag_in = r_tag[k-1];
        end

        assign trial = {rem_in, num_in[DIV_NUM_W-1]};
        assign ge    = trial >= {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? DIV_DEN_W'(trial - {1'b0, den_in}) : DIV_DEN_W'(trial);
                r_num[k] <= {num_in[DIV_NUM_W-2:0], 1'b0};
                r_quo[k] <= {quo_in[DIV_NUM_W-2:0], ge};
                r_den[k] <= den_in;
                r_tag[k] <= tag_in;
            end
        end
    end

    assign o_valid = r_vld[STAGES-1];
    assign o_quo   = r_quo[STAGES-1];
    assign o_tag   = r_tag[STAGES-1];

endmodule

[verif/aarh_hit_checker.sv]
`timescale 1ns / 1ps

module aarh_hit_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [aarh_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [aarh_pkg::COORD_W-1:0] i_cfg_data,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  logic [aarh_pkg::COORD_W-1:0] i_origin_x,
    input  logic [aarh_pkg::COORD_W-1:0] i_origin_y,
    input  logic [aarh_pkg::COORD_W-1:0] i_origin_z,
    input  logic [aarh_pkg::COORD_W-1:0] i_dir_x,
    input  logic [aarh_pkg::COORD_W-1:0] i_dir_y,
    input  logic [aarh_pkg::COORD_W-1:0] i_dir_z,
    input  logic [aarh_pkg::COORD_W-1:0] i_t_min,
    input  logic [aarh_pkg::COORD_W-1:0] i_t_max,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic                         i_hit,
    input  logic [aarh_pkg::COORD_W-1:0] i_hit_t,
    input  logic [aarh_pkg::COORD_W-1:0] i_point_x,
    input  logic [aarh_pkg::COORD_W-1:0] i_point_y,
    input  logic [aarh_pkg::COORD_W-1:0] i_point_z,
    input  logic [aarh_pkg::TEX_W-1:0]   i_tex_u,
    input  logic [aarh_pkg::TEX_W-1:0]   i_tex_v,
    input  logic [aarh_pkg::AXIS_W-1:0]  i_normal_axis,
    input  logic [aarh_pkg::MAT_W-1:0]   i_hit_material,
    output int                           o_fail_count,
    output int                           o_pending
);
    import aarh_pkg::*;

    typedef struct {
        logic               hit;
        logic [COORD_W-1:0] t;
        logic [COORD_W-1:0] pt [3];
        logic [TEX_W-1:0]   u;
        logic [TEX_W-1:0]   v;
        logic [AXIS_W-1:0]  axis;
        logic [MAT_W-1:0]   mat;
    } t_hit_beat;

    t_hit_beat expected_hits [$];

    logic [ORIENT_W-1:0] orient;
    longint plane;
    longint first_lo, first_hi, second_lo, second_hi;
    logic [MAT_W-1:0] material;

    function automatic longint to_long(input logic [COORD_W-1:0] x);
        longint r;
        r = longint'($signed(x));
        return r;
    endfunction

    function automatic longint clamp_coord(input longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic logic [TEX_W-1:0] tex_coord(input longint c, input longint lo,
                                                  input longint hi);
        longint q;
        if (hi == lo) return '0;
        q = ((c - lo) <<< FRAC_W) / (hi - lo);
        return q[TEX_W-1:0];
    endfunction

    function automatic t_hit_beat predict_hit(input logic [COORD_W-1:0] f [8]);
        t_hit_beat r;
        longint o [3];
        longint d [3];
        longint p [3];
        longint tt, tmin, tmax, c;
        int n, a1, a2;
        r.hit = 1'b0;
        r.t = '0;
        r.u = '0;
        r.v = '0;
        r.axis = '0;
        r.mat = '0;
        for (int i = 0; i < 3; i++) begin
            r.pt[i] = '0;
            o[i] = to_long(f[i]);
            d[i] = to_long(f[3+i]);
        end
        tmin = to_long(f[6]);
        tmax = to_long(f[7]);
        case (orient)
            ORIENT_XY: begin n = 2; a1 = 0; a2 = 1; end
            ORIENT_XZ: begin n = 1; a1 = 0; a2 = 2; end
            ORIENT_YZ: begin n = 0; a1 = 1; a2 = 2; end
            default: return r;
        endcase
        if (d[n] == 0) return r;
        tt = ((plane - o[n]) <<< FRAC_W) / d[n];
        if (tt < tmin || tt > tmax) return r;
        for (int i = 0; i < 3; i++) p[i] = o[i] + ((tt * d[i]) >>> FRAC_W);
        if (p[a1] < first_lo || p[a1] > first_hi || p[a2] < second_lo || p[a2] > second_hi)
            return r;
        r.hit = 1'b1;
        r.t = tt[COORD_W-1:0];
        for (int i = 0; i < 3; i++) begin
            c = clamp_coord(p[i]);
            r.pt[i] = c[COORD_W-1:0];
        end
        r.u = tex_coord(p[a1], first_lo, first_hi);
        r.v = tex_coord(p[a2], second_lo, second_hi);
        r.axis = n[AXIS_W-1:0];
        r.mat = material;
        return r;
    endfunction

    function automatic void report_miscompare(input t_hit_beat e, input t_hit_beat a);
        o_fail_count++;
        if (o_fail_count <= 10) begin
            $write("%0t mismatch: exp hit=%0d t=%h p=%h,%h,%h u=%h v=%h ax=%0d m=%h",
                   $realtime, e.hit, e.t, e.pt[0], e.pt[1], e.pt[2], e.u, e.v, e.axis,
                   e.mat);
            $display(" | got hit=%0d t=%h p=%h,%h,%h u=%h v=%h ax=%0d m=%h",
                     a.hit, a.t, a.pt[0], a.pt[1], a.pt[2], a.u, a.v, a.axis, a.mat);
        end
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_hit_beat got, want;
        logic [COORD_W-1:0] f [8];
        if (!i_rst_n) begin
            orient <= ORIENT_XY;
            plane <= 0;
            first_lo <= 0;
            first_hi <= 64'sd65536;
            second_lo <= 0;
            second_hi <= 64'sd65536;
            material <= '0;
            expected_hits.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ORIENT:      orient <= i_cfg_data[ORIENT_W-1:0];
                    REG_PLANE_OFST:  plane <= to_long(i_cfg_data);
                    REG_FIRST_LOW:   first_lo <= to_long(i_cfg_data);
                    REG_FIRST_HIGH:  first_hi <= to_long(i_cfg_data);
                    REG_SECOND_LOW:  second_lo <= to_long(i_cfg_data);
                    REG_SECOND_HIGH: second_hi <= to_long(i_cfg_data);
                    REG_MATERIAL:    material <= i_cfg_data[MAT_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                got.hit = i_hit;
                got.t = i_hit_t;
                got.pt[0] = i_point_x;
                got.pt[1] = i_point_y;
                got.pt[2] = i_point_z;
                got.u = i_tex_u;
                got.v = i_tex_v;
                got.axis = i_normal_axis;
                got.mat = i_hit_material;
                if (expected_hits.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t unexpected output beat hit=%0d t=%h", $realtime,
                                 i_hit, i_hit_t);
                end else begin
                    want = expected_hits.pop_front();
                    if (want.hit !== got.hit || want.t !== got.t || want.pt[0] !== got.pt[0] ||
                        want.pt[1] !== got.pt[1] || want.pt[2] !== got.pt[2] ||
                        want.u !== got.u || want.v !== got.v || want.axis !== got.axis ||
                        want.mat !== got.mat)
                        report_miscompare(want, got);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                f[0] = i_origin_x;
                f[1] = i_origin_y;
                f[2] = i_origin_z;
                f[3] = i_dir_x;
                f[4] = i_dir_y;
                f[5] = i_dir_z;
                f[6] = i_t_min;
                f[7] = i_t_max;
                expected_hits.push_back(predict_hit(f));
            end
        end
        o_pending <= expected_hits.size();
    end

endmodule

[verif/axis_aligned_rect_ray_hit_tb.sv]
`timescale 1ns / 1ps

module axis_aligned_rect_ray_hit_tb;
    import aarh_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [IDX_W-1:0] cfg_idx = '0;
    logic [COORD_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [COORD_W-1:0] ray [8] = '{default: '0};
    logic out_valid;
    logic out_stall = 1'b1;
    logic hit;
    logic signed [COORD_W-1:0] hit_t, pt_x, pt_y, pt_z;
    logic [TEX_W-1:0] tex_u, tex_v;
    logic [AXIS_W-1:0] axis;
    logic [MAT_W-1:0] mat;
    int fail_count, pending;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    logic [ORIENT_W-1:0] cur_orient;
    longint cur_plane, cur_flo, cur_fhi, cur_slo, cur_shi;

    always #4 i_clk = ~i_clk;

    axis_aligned_rect_ray_hit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_origin_x(ray[0]), .i_origin_y(ray[1]), .i_origin_z(ray[2]),
        .i_dir_x(ray[3]), .i_dir_y(ray[4]), .i_dir_z(ray[5]),
        .i_t_min(ray[6]), .i_t_max(ray[7]),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_hit(hit), .o_hit_t(hit_t), .o_point_x(pt_x), .o_point_y(pt_y), .o_point_z(pt_z),
        .o_tex_u(tex_u), .o_tex_v(tex_v), .o_normal_axis(axis), .o_hit_material(mat)
    );

    aarh_hit_checker i_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_origin_x(ray[0]), .i_origin_y(ray[1]), .i_origin_z(ray[2]),
        .i_dir_x(ray[3]), .i_dir_y(ray[4]), .i_dir_z(ray[5]),
        .i_t_min(ray[6]), .i_t_max(ray[7]),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_hit(hit), .i_hit_t(hit_t), .i_point_x(pt_x), .i_point_y(pt_y),
        .i_point_z(pt_z), .i_tex_u(tex_u), .i_tex_v(tex_v), .i_normal_axis(axis),
        .i_hit_material(mat), .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(negedge i_clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic send_ray(input longint ox, oy, oz, dx, dy, dz, tn, tx);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        ray[0] <= ox[31:0];
        ray[1] <= oy[31:0];
        ray[2] <= oz[31:0];
        ray[3] <= dx[31:0];
        ray[4] <= dy[31:0];
        ray[5] <= dz[31:0];
        ray[6] <= tn[31:0];
        ray[7] <= tx[31:0];
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (110) @(negedge i_clk);
    endtask

    // drain, then load every register and poke the unused index
    task automatic set_plane(input logic [ORIENT_W-1:0] o, input longint pl, flo, fhi,
                             slo, shi, input logic [MAT_W-1:0] m);
        longint vals [7];
        drain();
        vals = '{longint'(o), pl, flo, fhi, slo, shi, longint'(m)};
        for (int i = 0; i < 8; i++) begin
            cfg_we <= 1'b1;
            cfg_idx <= i[IDX_W-1:0];
            cfg_data <= (i < 7) ? vals[i][31:0] : $urandom;
            @(negedge i_clk);
        end
        cfg_we <= 1'b0;
        @(negedge i_clk);
        cur_orient = o;
        cur_plane = pl;
        cur_flo = flo;
        cur_fhi = fhi;
        cur_slo = slo;
        cur_shi = shi;
    endtask

    function automatic longint rand_span(input int lo, input int hi);
        return longint'(lo) + longint'($urandom_range(hi - lo));
    endfunction

    task automatic send_random_ray();
        longint p [3];
        longint d [3];
        longint o [3];
        longint tt, tn, tx;
        int n, a1, a2, kind;
        kind = $urandom_range(99);
        if (kind < 15) begin
            send_ray($signed($urandom), $signed($urandom), $signed($urandom),
                     $signed($urandom), $signed($urandom), $signed($urandom),
                     $signed($urandom), $signed($urandom));
            return;
        end
        case (cur_orient)
            ORIENT_XZ: begin n = 1; a1 = 0; a2 = 2; end
            ORIENT_YZ: begin n = 0; a1 = 1; a2 = 2; end
            default:   begin n = 2; a1 = 0; a2 = 1; end
        endcase
        p[n] = cur_plane;
        p[a1] = cur_flo + (((cur_fhi - cur_flo) * rand_span(-10, 110)) / 100);
        p[a2] = cur_slo + (((cur_shi - cur_slo) * rand_span(-10, 110)) / 100);
        for (int i = 0; i < 3; i++) d[i] = rand_span(-262144, 262144);
        if (kind < 25) d[n] = 0;
        else if (d[n] == 0) d[n] = 65536;
        tt = rand_span(0, 524288);
        for (int i = 0; i < 3; i++) o[i] = p[i] - ((tt * d[i]) >>> 16);
        tn = tt - rand_span(-4096, 131072);
        tx = tt + rand_span(-4096, 131072);
        send_ray(o[0], o[1], o[2], d[0], d[1], d[2], tn, tx);
    endtask

    initial begin
        longint lim;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part, default unit square at z = 0
        cur_orient = ORIENT_XY; cur_plane = 0;
        cur_flo = 0; cur_fhi = 65536; cur_slo = 0; cur_shi = 65536;
        send_ray(32768, 32768, 65536, 0, 0, -65536, 0, 131072);
        send_ray(32768, 32768, 65536, 0, 0, 0, 0, 131072);
        send_ray(32768, 32768, 65536, 0, 0, -65536, 131072, 262144);
        send_ray(0, 65536, 65536, 0, 0, -65536, 65536, 65536);
        send_ray(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
                 -64'sd2147483648, -64'sd2147483648, -64'sd2147483648, -64'sd2147483648);
        send_ray(64'sd2147483647, 64'sd2147483647, 64'sd2147483647, 64'sd2147483647,
                 64'sd2147483647, 64'sd2147483647, -64'sd2147483648, 64'sd2147483647);
        set_plane(ORIENT_XZ, 65536, -131072, 131072, -65536, 65536, 8'hff);
        send_ray(0, 0, 0, 65536, 65536, 65536, 0, 131072);
        send_ray(0, 0, 0, 0, 0, 0, -64'sd2147483648, 64'sd2147483647);
        set_plane(ORIENT_YZ, -65536, 32768, 32768, 0, 65536, 8'h5a);
        send_ray(0, 32768, 16384, -65536, 0, 0, 0, 131072);
        send_ray(0, 32768, 16384, 65536, 0, 0, -131072, 131072);
        set_plane(ORIENT_XY, 0, 65536, 0, 0, 65536, 8'h01);
        send_ray(32768, 32768, 65536, 0, 0, -65536, 0, 131072);
        set_plane(2'd3, 0, -64'sd2147483648, 64'sd2147483647, -64'sd2147483648,
                  64'sd2147483647, 8'h33);
        send_ray(0, 0, 65536, 0, 0, -65536, -64'sd2147483648, 64'sd2147483647);
        set_plane(ORIENT_XY, 64'sd2147483647, -64'sd2147483648, 64'sd2147483647,
                  -64'sd2147483648, 64'sd2147483647, 8'h80);
        send_ray(0, 0, 64'sd2147483000, 3, -5, 7, -64'sd2147483648, 64'sd2147483647);
        send_ray(-1000, 1000, 64'sd2147480000, 65535, 65537, 65536, 0, 64'sd2147483647);
        set_plane(ORIENT_XZ, -64'sd2147483648, -64'sd2147483648, 64'sd2147483647,
                  -64'sd2147483648, 64'sd2147483647, 8'h7f);
        send_ray(5, 5, -64'sd2147480000, 3, -65536, 9, -64'sd2147483648, 64'sd2147483647);

        // random part
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 8 : (ph == 1) ? 74 : 0;
            recv_stall_pct = (ph == 0) ? 74 : (ph == 1) ? 8 : 0;
            for (int blk = 0; blk < 4; blk++) begin
                lim = rand_span(-1048576, 1048576);
                set_plane((ph == 1 && blk == 3) ? 2'd3 : 2'(blk % 3),
                          rand_span(-1048576, 1048576), lim, lim + rand_span(0, 1048576),
                          -lim, -lim + rand_span(0, 1048576), MAT_W'($urandom));
                for (int k = 0; k < 108; k++) send_random_ray();
            end
        end

        in_valid <= 1'b0;
        lim = 0;
        while (pending != 0 && lim < 100000) begin
            @(negedge i_clk);
            lim++;
        end
        repeat (120) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
